/* hw/rtl/pcpc_pkg.sv */
// Shared constants, codes and types of the photon cluster pixel classifier.
package pcpc_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  // Field and counter widths
  localparam int VAL_W      = 20;                          // pixel value, signed Q16.4
  localparam int RMS_W      = 16;                          // pedestal rms, Q12.4
  localparam int SIGMA_W    = 8;                           // sigma, Q4.4
  localparam int DIM_W      = 10;                          // width and height registers
  localparam int COORD_W    = 9;                           // reported row and column
  localparam int CLASS_W    = 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);           // column counter and line address
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 3);      // row counter, runs past the frame
  localparam int PEND_W     = $clog2(MAX_WIDTH + 2);       // pixels waiting for a flush
  localparam int THR_W      = SIGMA_W + RMS_W;             // threshold, Q16.8
  localparam int CMP_W      = 30;                          // common width for Q.8 compares

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = DIM_W;

  // Decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SIGMA  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = CFG_ADDR_W'(2);

  // Register reset values
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = SIGMA_W'(80);
  localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(400);

  // Request kinds carried on tuser
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Pixel classes
  typedef enum logic [CLASS_W-1:0] {
    CLS_PEDESTAL    = 2'd0,
    CLS_PHOTON      = 2'd1,
    CLS_CLUSTER_MAX = 2'd2,
    CLS_NEGATIVE    = 2'd3
  } pix_class_t;

  // One window step handed from the front to the back
  typedef struct packed {
    logic [VAL_W-1:0]   val;        // newest pixel of the fetched column
    logic [RMS_W-1:0]   rms;
    logic [COL_W-1:0]   col;        // column of the step, line buffer address
    logic               emit;       // a classified pixel comes out of this step
    logic [COORD_W-1:0] row_q;      // position of the classified pixel
    logic [COORD_W-1:0] col_q;
    logic               frame_end;
    logic               bnd_top;    // window rows and columns that fall outside the frame
    logic               bnd_bot;
    logic               bnd_left;
    logic               bnd_right;
  } step_tok_t;

endpackage

/* hw/rtl/pcpc_front.sv */
// Front end: accepts pixel and flush requests, tracks the frame position, issues window steps.
module pcpc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pcpc_pkg::DIM_W-1:0]    frame_width,
  input  logic [pcpc_pkg::DIM_W-1:0]    frame_height,
  input  logic                          geom_wr,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pcpc_pkg::IN_TDATA_W-1:0] in_tdata,  // [19:0] pixel_value, [35:20] pixel_rms
  input  logic                          in_tuser,  // [0] req_type
  input  logic                          q_full,
  output logic                          q_push,
  output pcpc_pkg::step_tok_t           q_tok
);
  import pcpc_pkg::*;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              flushing_r, flushing_nxt;
  logic              extra_r, extra_nxt;

  logic [DIM_W-1:0]  w_c, h_c, col_p1;
  logic [ROW_W-1:0]  pos_row, next_row, qr, h_m1;
  logic [COL_W-1:0]  pos_col, next_col, qc;
  logic              accept, is_pix, vc0, col_wrap, is_last;

  // Clamp the geometry to the supported range
  always_comb begin
    w_c = frame_width;
    if (frame_width == '0) begin
      w_c = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      w_c = DIM_W'(MAX_WIDTH);
    end
    h_c = frame_height;
    if (frame_height == '0) begin
      h_c = DIM_W'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      h_c = DIM_W'(MAX_HEIGHT);
    end
  end

  // Hold requests while the extra step of a one-row frame goes out
  assign in_tready = !q_full && !extra_r;
  assign accept    = in_tvalid && in_tready;
  assign is_pix    = (in_tuser == REQ_PIXEL);

  // Position of this step and of the pixel it completes
  always_comb begin
    pos_row = row_r;
    pos_col = col_r;
    if (!extra_r && is_pix && flushing_r) begin
      pos_row = '0;
      pos_col = '0;
    end
    col_p1   = DIM_W'(pos_col) + DIM_W'(1);
    col_wrap = (col_p1 >= w_c);
    next_col = col_wrap ? '0 : col_p1[COL_W-1:0];
    next_row = col_wrap ? pos_row + ROW_W'(1) : pos_row;
    vc0      = (pos_col == '0);
    h_m1     = ROW_W'(h_c) - ROW_W'(1);
    qr       = vc0 ? pos_row - ROW_W'(2) : pos_row - ROW_W'(1);
    qc       = vc0 ? COL_W'(w_c - DIM_W'(1)) : pos_col - COL_W'(1);
    is_last  = (pos_row == h_m1) && (col_p1 == w_c);
  end

  // Build the step request
  always_comb begin
    q_tok.val       = (is_pix && !extra_r) ? in_tdata[VAL_W-1:0] : '0;
    q_tok.rms       = (is_pix && !extra_r) ? in_tdata[VAL_W+RMS_W-1:VAL_W] : '0;
    q_tok.col       = pos_col;
    q_tok.emit      = (pos_row >= ROW_W'(2)) || ((pos_row == ROW_W'(1)) && !vc0);
    q_tok.row_q     = COORD_W'(qr);
    q_tok.col_q     = COORD_W'(qc);
    q_tok.frame_end = (qr == h_m1) && vc0;
    q_tok.bnd_top   = (qr == '0);
    q_tok.bnd_bot   = (qr == h_m1);
    q_tok.bnd_left  = (qc == '0);
    q_tok.bnd_right = vc0;
    if (extra_r) begin
      q_push = !q_full;
    end else begin
      q_push = accept && (is_pix || (pend_r != '0));
    end
  end

  // Advance the frame position
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    pend_nxt     = pend_r;
    flushing_nxt = flushing_r;
    extra_nxt    = extra_r;
    if (geom_wr) begin
      row_nxt      = '0;
      col_nxt      = '0;
      pend_nxt     = '0;
      flushing_nxt = 1'b0;
      extra_nxt    = 1'b0;
    end else if (extra_r) begin
      if (!q_full) begin
        row_nxt   = next_row;
        col_nxt   = next_col;
        extra_nxt = 1'b0;
      end
    end else if (accept) begin
      if (is_pix) begin
        if (is_last) begin
          // Frame done: run on past the last row for the flushes
          row_nxt      = ROW_W'(h_c);
          col_nxt      = '0;
          flushing_nxt = 1'b1;
          pend_nxt     = (h_c == DIM_W'(1)) ? PEND_W'(w_c) : PEND_W'(w_c) + PEND_W'(1);
          extra_nxt    = (h_c == DIM_W'(1));
        end else begin
          row_nxt      = next_row;
          col_nxt      = next_col;
          flushing_nxt = 1'b0;
          pend_nxt     = '0;
        end
      end else if (pend_r != '0) begin
        row_nxt  = next_row;
        col_nxt  = next_col;
        pend_nxt = pend_r - PEND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      pend_r     <= '0;
      flushing_r <= 1'b0;
      extra_r    <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      pend_r     <= pend_nxt;
      flushing_r <= flushing_nxt;
      extra_r    <= extra_nxt;
    end
  end

endmodule

/* hw/rtl/pcpc_queue.sv */
// Short FIFO of window steps between the front end and the back end.
module pcpc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcpc_pkg::step_tok_t push_tok,
  output logic                full,
  input  logic                pop,
  output pcpc_pkg::step_tok_t head_tok,
  output logic                empty
);
  import pcpc_pkg::*;

  step_tok_t          slot_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == (Q_PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_tok = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (Q_PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (Q_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

/* hw/rtl/pcpc_back.sv */
// Back end: line buffers, 3x3 window, threshold tests and the result register.
module pcpc_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [pcpc_pkg::SIGMA_W-1:0]     sigma,
  input  logic                             q_empty,
  input  pcpc_pkg::step_tok_t              q_head,
  output logic                             q_pop,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [pcpc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [1:0] pixel_class, [10:2] out_row,
                                                       // [19:11] out_col, [23:20] zero
  output logic                             out_tlast   // frame_end
);
  import pcpc_pkg::*;

  localparam int QUAD_W = VAL_W + 2;
  localparam int TOT_W  = VAL_W + 4;

  typedef struct packed {
    logic [VAL_W-1:0] row1_val;   // previous row
    logic [RMS_W-1:0] row1_rms;
    logic [VAL_W-1:0] row2_val;   // two rows up
  } line_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] row_q;
    logic [COORD_W-1:0] col_q;
    logic               frame_end;
  } pix_tag_t;

  logic adv;

  // Line buffer
  line_word_t line_mem [MAX_WIDTH];
  line_word_t rd_word_r, fwd_word_r, col_word, wr_word;
  logic       fwd_r;

  // Step stage
  logic       s1_vld_r;
  step_tok_t  s1_tok_r;
  logic signed [VAL_W-1:0] col_a_r [3];
  logic signed [VAL_W-1:0] col_b_r [3];
  logic [RMS_W-1:0]        rms_b_r;
  logic signed [VAL_W-1:0] new_col [3];
  logic signed [VAL_W-1:0] win [3][3];

  // Sum stage
  logic                    s2_vld_r;
  logic signed [VAL_W-1:0] s2_win_r [3][3];
  logic [RMS_W-1:0]        s2_rms_r;
  pix_tag_t                s2_tag_r;
  logic [THR_W-1:0]        thr;
  logic signed [QUAD_W-1:0] quad [4];
  logic signed [TOT_W-1:0]  tot;
  logic signed [VAL_W-1:0]  rmax [3];

  // Decision stage
  logic                     s3_vld_r;
  pix_tag_t                 s3_tag_r;
  logic [THR_W-1:0]         thr_r;
  logic signed [QUAD_W-1:0] quad_r [4];
  logic signed [TOT_W-1:0]  tot_r;
  logic signed [VAL_W-1:0]  rmax_r [3];
  logic signed [VAL_W-1:0]  centre_r;
  logic signed [VAL_W-1:0]  mx01, mx012, mx;
  logic signed [CMP_W-1:0]  thr_x, cen_x, mx_x, tot_x;
  logic signed [CMP_W-1:0]  quad_x [4];
  logic                     neg, hit_quad, photon;
  pix_class_t               cls;

  // Result register
  logic       out_vld_r;
  pix_class_t out_cls_r;
  pix_tag_t   out_tag_r;

  // Move the whole pipe unless a result waits on a stalled receiver
  assign adv   = !out_vld_r || out_tready;
  assign q_pop = adv && !q_empty;

  // Read the column of the next step; write back the shifted column of this step
  always_comb begin
    col_word         = fwd_r ? fwd_word_r : rd_word_r;
    wr_word.row1_val = s1_tok_r.val;
    wr_word.row1_rms = s1_tok_r.rms;
    wr_word.row2_val = col_word.row1_val;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_vld_r) begin
        line_mem[s1_tok_r.col] <= wr_word;
      end
      rd_word_r  <= line_mem[q_head.col];
      fwd_word_r <= wr_word;
      fwd_r      <= s1_vld_r && (s1_tok_r.col == q_head.col);
    end
  end

  // Load the step stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tok_r <= q_head;
    end
  end

  // Assemble the window and zero the parts outside the frame
  always_comb begin
    new_col[0] = $signed(col_word.row2_val);
    new_col[1] = $signed(col_word.row1_val);
    new_col[2] = $signed(s1_tok_r.val);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((s1_tok_r.bnd_top && r == 0) || (s1_tok_r.bnd_bot && r == 2) ||
            (s1_tok_r.bnd_left && c == 0) || (s1_tok_r.bnd_right && c == 2)) begin
          win[r][c] = '0;
        end else if (c == 0) begin
          win[r][c] = col_a_r[r];
        end else if (c == 1) begin
          win[r][c] = col_b_r[r];
        end else begin
          win[r][c] = new_col[r];
        end
      end
    end
  end

  // Shift the window columns
  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      for (int r = 0; r < 3; r++) begin
        col_a_r[r] <= col_b_r[r];
        col_b_r[r] <= new_col[r];
      end
      rms_b_r <= col_word.row1_rms;
    end
  end

  // Load the sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r && s1_tok_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_win_r           <= win;
      s2_rms_r           <= rms_b_r;
      s2_tag_r.row_q     <= s1_tok_r.row_q;
      s2_tag_r.col_q     <= s1_tok_r.col_q;
      s2_tag_r.frame_end <= s1_tok_r.frame_end;
    end
  end

  // Threshold product, quadrant sums, total and row maxima
  always_comb begin
    thr     = THR_W'(sigma) * THR_W'(s2_rms_r);
    quad[0] = QUAD_W'(s2_win_r[0][0]) + QUAD_W'(s2_win_r[0][1]) +
              QUAD_W'(s2_win_r[1][0]) + QUAD_W'(s2_win_r[1][1]);
    quad[1] = QUAD_W'(s2_win_r[0][1]) + QUAD_W'(s2_win_r[0][2]) +
              QUAD_W'(s2_win_r[1][1]) + QUAD_W'(s2_win_r[1][2]);
    quad[2] = QUAD_W'(s2_win_r[1][0]) + QUAD_W'(s2_win_r[1][1]) +
              QUAD_W'(s2_win_r[2][0]) + QUAD_W'(s2_win_r[2][1]);
    quad[3] = QUAD_W'(s2_win_r[1][1]) + QUAD_W'(s2_win_r[1][2]) +
              QUAD_W'(s2_win_r[2][1]) + QUAD_W'(s2_win_r[2][2]);
    tot = '0;
    for (int r = 0; r < 3; r++) begin
      tot = tot + TOT_W'(s2_win_r[r][0]) + TOT_W'(s2_win_r[r][1]) + TOT_W'(s2_win_r[r][2]);
      rmax[r] = (s2_win_r[r][0] > s2_win_r[r][1]) ? s2_win_r[r][0] : s2_win_r[r][1];
      rmax[r] = (s2_win_r[r][2] > rmax[r]) ? s2_win_r[r][2] : rmax[r];
    end
  end

  // Load the decision stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      thr_r    <= thr;
      quad_r   <= quad;
      tot_r    <= tot;
      rmax_r   <= rmax;
      centre_r <= s2_win_r[1][1];
      s3_tag_r <= s2_tag_r;
    end
  end

  // Compare in Q.8 and pick the class
  always_comb begin
    mx01  = (rmax_r[0] > rmax_r[1]) ? rmax_r[0] : rmax_r[1];
    mx012 = (rmax_r[2] > mx01) ? rmax_r[2] : mx01;
    mx    = (mx012 > 0) ? mx012 : '0;
    thr_x = CMP_W'(thr_r);
    cen_x = CMP_W'(centre_r) <<< 4;
    mx_x  = CMP_W'(mx) <<< 4;
    tot_x = CMP_W'(tot_r) <<< 4;
    hit_quad = 1'b0;
    for (int k = 0; k < 4; k++) begin
      quad_x[k] = CMP_W'(quad_r[k]) <<< 4;
      hit_quad  = hit_quad || (quad_x[k] > (thr_x <<< 1));
    end
    neg    = (cen_x < -thr_x);
    photon = (mx_x > thr_x) || hit_quad || (tot_x > (thr_x + (thr_x <<< 1)));
    if (neg) begin
      cls = CLS_NEGATIVE;
    end else if (photon) begin
      cls = (centre_r == mx) ? CLS_CLUSTER_MAX : CLS_PHOTON;
    end else begin
      cls = CLS_PEDESTAL;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_vld_r) begin
      out_cls_r <= cls;
      out_tag_r <= s3_tag_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - CLASS_W - 2 * COORD_W)'(0), out_tag_r.col_q,
                       out_tag_r.row_q, out_cls_r};
  assign out_tlast  = out_tag_r.frame_end;

endmodule

/* hw/rtl/photon_cluster_pixel_classifier_top.sv */
// Top level of the photon cluster pixel classifier: configuration registers and the two halves.
//
// Usage: pixels enter on the in_ stream in raster order, one request per pixel with
// req_type on in_tuser low, pixel_value and pixel_rms on in_tdata. Each pixel is
// classified from its 3x3 neighborhood (outside the frame counts as zero) and comes out
// on the out_ stream with class, row and column; out_tlast marks the frame's last pixel.
// A pixel's result is due once pixel row+1, col+1 has arrived; the last width+1 pixels
// of a frame are drained by flush requests (in_tuser high), one result per flush.
// Flushes with nothing pending give no result. A new pixel after a frame's end drops
// what is still pending and starts the next frame.
// Throughput: one request per cycle while in_tready is high. A request that completes a
// result is registered in the request queue, the line buffer read, the sum stage, the
// compare stage and the result register. At the end of a one-row frame in_tready
// drops while the window is advanced over the missing row.
// A 4-entry request queue sits between front and back: when the receiver holds
// out_tready low the back end stops and requests keep being accepted until it fills.
// Reset (rst_n low, synchronous) restores the register defaults and empties the
// pipeline; the line buffers are not cleared, as unwritten entries are never used.
// Writing frame_width or frame_height restarts the frame position.
module photon_cluster_pixel_classifier_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pcpc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [19:0] pixel_value, [35:20] pixel_rms,
                                                       // [39:36] zero
  input  logic                             in_tuser,   // [0] req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pcpc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [1:0] pixel_class, [10:2] out_row,
                                                       // [19:11] out_col, [23:20] zero
  output logic                             out_tlast,  // frame_end
  input  logic                             cfg_wr_en,
  input  logic [pcpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pcpc_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import pcpc_pkg::*;

  logic [SIGMA_W-1:0] sigma_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic               geom_wr;

  logic      q_push, q_full, q_pop, q_empty;
  step_tok_t q_tok, q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r  <= SIGMA_RESET;
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SIGMA:  sigma_r  <= cfg_wr_data[SIGMA_W-1:0];
        REG_WIDTH:  width_r  <= cfg_wr_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_wr_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Restart the frame on any geometry write
  assign geom_wr = cfg_wr_en && ((cfg_addr == REG_WIDTH) || (cfg_addr == REG_HEIGHT));

  pcpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (width_r),
    .frame_height (height_r),
    .geom_wr      (geom_wr),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tok        (q_tok)
  );

  pcpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (q_tok),
    .full     (q_full),
    .pop      (q_pop),
    .head_tok (q_head),
    .empty    (q_empty)
  );

  pcpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .sigma      (sigma_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
